@@ src/psm_pkg.sv @@
// Shared types, constants and helper functions of the postfix stack machine.
`default_nettype none
package psm_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int NAME_COUNT  = 52;

   localparam int VAL_W     = 48;
   localparam int FRAC_W    = 16;
   localparam int HALF_W    = VAL_W / 2;
   localparam int PROD_W    = 2 * VAL_W;
   localparam int DIVD_W    = VAL_W + FRAC_W;
   localparam int SATIN_W   = PROD_W - FRAC_W;
   localparam int SP_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
   localparam int NAME_W    = (NAME_COUNT > 1) ? $clog2(NAME_COUNT) : 1;
   localparam int DIV_STEPS = DIVD_W;
   localparam int MUL_STEPS = 4;
   localparam int CTR_MAX   = (DIV_STEPS > STACK_DEPTH) ? DIV_STEPS : STACK_DEPTH;
   localparam int CTR_W     = $clog2(CTR_MAX + 1);

   localparam logic [3:0] MODE_DIGIT = 4'd0;
   localparam logic [3:0] MODE_NAME  = 4'd1;
   localparam logic [3:0] MODE_FETCH = 4'd2;
   localparam logic [3:0] MODE_STORE = 4'd3;
   localparam logic [3:0] MODE_ADD   = 4'd4;
   localparam logic [3:0] MODE_SUB   = 4'd5;
   localparam logic [3:0] MODE_MUL   = 4'd6;
   localparam logic [3:0] MODE_DIV   = 4'd7;
   localparam logic [3:0] MODE_DUMP  = 4'd8;

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_UNDER = 3'd1;
   localparam logic [2:0] ST_OVER  = 3'd2;
   localparam logic [2:0] ST_TYPE  = 3'd3;
   localparam logic [2:0] ST_DIV0  = 3'd4;

   localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   typedef struct packed {
      logic [3:0] mode;
      logic [5:0] literal;
   } req_type;

   typedef struct packed {
      logic [2:0]        status;
      logic [VAL_W-1:0]  entry_value;
      logic              entry_is_name;
      logic [4:0]        depth;
      logic              last;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE, S_RD_TOP, S_RD_NEXT, S_LATCH_A, S_EVAL, S_FETCH, S_RELOAD,
      S_RELOAD_LAT, S_MUL, S_DIV, S_BIN_WB, S_EMIT, S_DUMP_RD, S_DUMP_LAT,
      S_DUMP_EMIT
   } state_type;

   typedef enum logic [1:0] {RD_TOP, RD_SECOND, RD_DUMP} rd_sel_type;

   typedef enum logic [2:0] {
      SOP_NONE, SOP_PUSH, SOP_FETCH, SOP_BIN, SOP_STORE
   } sop_type;

   typedef enum logic {RPT_TOP, RPT_RDATA} rpt_type;

   typedef struct packed {
      logic              load_req;
      rd_sel_type        rd_sel;
      logic [SP_W-1:0]   dump_idx;
      logic              latch_b;
      logic              latch_a;
      logic              st_load;
      sop_type           sop;
      logic              rpt_load;
      rpt_type           rpt_sel;
      logic              arith_init;
      logic              mul_step;
      logic [1:0]        mul_sel;
      logic              div_step;
      logic              emit;
      logic              last;
   } cmd_type;

   typedef struct packed {
      logic [3:0]        mode;
      logic [2:0]        err;
      logic [CNT_W-1:0]  count;
      logic              out_free;
   } stat_type;

   // Gives a magnitude its sign and clamps it to the value range.
   function automatic logic [VAL_W-1:0] sat_mag(input logic [SATIN_W-1:0] mag,
                                               input logic neg);
      logic [VAL_W-1:0] res;
      if (neg) begin
         if (mag >= SATIN_W'({1'b1, {(VAL_W-1){1'b0}}})) res = VAL_MIN;
         else res = VAL_W'(-mag[VAL_W-1:0]);
      end else begin
         if (mag > SATIN_W'(VAL_MAX)) res = VAL_MAX;
         else res = mag[VAL_W-1:0];
      end
      return res;
   endfunction

   // Clamps a sum that carries one guard bit.
   function automatic logic [VAL_W-1:0] sat_sum(input logic [VAL_W:0] s);
      logic [VAL_W-1:0] res;
      if (s[VAL_W] != s[VAL_W-1]) res = s[VAL_W] ? VAL_MIN : VAL_MAX;
      else res = s[VAL_W-1:0];
      return res;
   endfunction

endpackage
`default_nettype wire

@@ src/psm_dp.sv @@
// Datapath: operand stack memory, variable store, arithmetic units and result word register.
`default_nettype none
module psm_dp (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire psm_pkg::req_type  req_data,
   input  wire psm_pkg::cmd_type  cmd,
   output psm_pkg::stat_type      status,
   input  wire logic              rsp_stall,
   output logic                   rsp_valid,
   output psm_pkg::rsp_type       rsp_data
);

   logic [3:0]                     mode_ff, mode_in;
   logic [5:0]                     lit_ff, lit_in;
   logic [psm_pkg::CNT_W-1:0]      count_ff, count_in;
   logic [psm_pkg::VAL_W-1:0]      b_ff, b_in, a_ff, a_in;
   logic                           b_tag_ff, b_tag_in, a_tag_ff, a_tag_in;
   logic [psm_pkg::VAL_W:0]        stk_mem [psm_pkg::STACK_DEPTH];
   logic [psm_pkg::VAL_W:0]        rd_ff;
   logic [psm_pkg::VAL_W-1:0]      var_mem [psm_pkg::NAME_COUNT];
   logic [psm_pkg::NAME_COUNT-1:0] var_valid_ff, var_valid_in;
   logic [psm_pkg::VAL_W-1:0]      var_rd_ff;
   logic                           var_hit_ff;
   logic [psm_pkg::PROD_W-1:0]     acc_ff, acc_in;
   logic [psm_pkg::DIVD_W-1:0]     quo_ff, quo_in;
   logic [psm_pkg::VAL_W-1:0]      rem_ff, rem_in;
   logic [psm_pkg::VAL_W-1:0]      r_val_ff, r_val_in;
   logic                           r_name_ff, r_name_in;
   logic [2:0]                     r_status_ff, r_status_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   psm_pkg::rsp_type               rsp_data_ff, rsp_data_in;

   logic [psm_pkg::SP_W-1:0]   rd_addr, wr_addr;
   logic                       stk_we;
   logic [psm_pkg::VAL_W:0]    wr_data;
   logic [psm_pkg::VAL_W:0]    push_data;
   logic [psm_pkg::VAL_W-1:0]  bin_res, fetch_val;
   logic [psm_pkg::VAL_W-1:0]  mag_a, mag_b;
   logic                       neg;
   logic [2:0]                 err;
   logic [psm_pkg::HALF_W-1:0] mul_x, mul_y;
   logic [psm_pkg::VAL_W-1:0]  prod;
   logic [psm_pkg::PROD_W-1:0] pp;
   logic [psm_pkg::VAL_W:0]    shifted;
   logic                       var_in_range;
   logic [psm_pkg::NAME_W-1:0] var_wr_idx, var_rd_idx;

   assign mag_a = a_ff[psm_pkg::VAL_W-1] ? psm_pkg::VAL_W'(-a_ff) : a_ff;
   assign mag_b = b_ff[psm_pkg::VAL_W-1] ? psm_pkg::VAL_W'(-b_ff) : b_ff;
   assign neg   = a_ff[psm_pkg::VAL_W-1] ^ b_ff[psm_pkg::VAL_W-1];

   assign var_rd_idx   = b_ff[psm_pkg::NAME_W-1:0];
   assign var_wr_idx   = a_ff[psm_pkg::NAME_W-1:0];
   assign var_in_range = a_ff < psm_pkg::VAL_W'(psm_pkg::NAME_COUNT);
   assign fetch_val    = var_hit_ff ? var_rd_ff : '0;

   // Error checks: overflow for a push; otherwise in the order underflow, entry kind, zero divisor.
   always_comb begin
      err = psm_pkg::ST_OK;
      case (mode_ff)
         psm_pkg::MODE_DIGIT, psm_pkg::MODE_NAME: begin
            if (count_ff == psm_pkg::CNT_W'(psm_pkg::STACK_DEPTH)) err = psm_pkg::ST_OVER;
         end
         psm_pkg::MODE_FETCH: begin
            if (count_ff == '0) err = psm_pkg::ST_UNDER;
            else if (!b_tag_ff) err = psm_pkg::ST_TYPE;
         end
         psm_pkg::MODE_STORE: begin
            if (count_ff < psm_pkg::CNT_W'(2)) err = psm_pkg::ST_UNDER;
            else if (b_tag_ff || !a_tag_ff) err = psm_pkg::ST_TYPE;
         end
         psm_pkg::MODE_ADD, psm_pkg::MODE_SUB, psm_pkg::MODE_MUL, psm_pkg::MODE_DIV: begin
            if (count_ff < psm_pkg::CNT_W'(2)) err = psm_pkg::ST_UNDER;
            else if (b_tag_ff || a_tag_ff) err = psm_pkg::ST_TYPE;
            else if (mode_ff == psm_pkg::MODE_DIV && b_ff == '0) err = psm_pkg::ST_DIV0;
         end
         default: err = psm_pkg::ST_OK;
      endcase
   end

   always_comb begin
      case (mode_ff)
         psm_pkg::MODE_ADD:
            bin_res = psm_pkg::sat_sum({a_ff[psm_pkg::VAL_W-1], a_ff}
                                       + {b_ff[psm_pkg::VAL_W-1], b_ff});
         psm_pkg::MODE_SUB:
            bin_res = psm_pkg::sat_sum({a_ff[psm_pkg::VAL_W-1], a_ff}
                                       - {b_ff[psm_pkg::VAL_W-1], b_ff});
         psm_pkg::MODE_MUL:
            bin_res = psm_pkg::sat_mag(acc_ff[psm_pkg::PROD_W-1:psm_pkg::FRAC_W], neg);
         default:
            bin_res = psm_pkg::sat_mag(psm_pkg::SATIN_W'(quo_ff), neg);
      endcase
   end

   assign push_data = (mode_ff == psm_pkg::MODE_NAME)
                      ? {1'b1, psm_pkg::VAL_W'(lit_ff)}
                      : {1'b0, psm_pkg::VAL_W'(lit_ff) << psm_pkg::FRAC_W};

   always_comb begin
      case (cmd.rd_sel)
         psm_pkg::RD_TOP:    rd_addr = psm_pkg::SP_W'(count_ff - psm_pkg::CNT_W'(1));
         psm_pkg::RD_SECOND: rd_addr = psm_pkg::SP_W'(count_ff - psm_pkg::CNT_W'(2));
         default:            rd_addr = cmd.dump_idx;
      endcase
   end

   always_comb begin
      stk_we   = 1'b0;
      wr_addr  = psm_pkg::SP_W'(count_ff);
      wr_data  = push_data;
      count_in = count_ff;
      case (cmd.sop)
         psm_pkg::SOP_PUSH: begin
            stk_we   = 1'b1;
            count_in = count_ff + psm_pkg::CNT_W'(1);
         end
         psm_pkg::SOP_FETCH: begin
            stk_we  = 1'b1;
            wr_addr = psm_pkg::SP_W'(count_ff - psm_pkg::CNT_W'(1));
            wr_data = {1'b0, fetch_val};
         end
         psm_pkg::SOP_BIN: begin
            stk_we   = 1'b1;
            wr_addr  = psm_pkg::SP_W'(count_ff - psm_pkg::CNT_W'(2));
            wr_data  = {1'b0, bin_res};
            count_in = count_ff - psm_pkg::CNT_W'(1);
         end
         psm_pkg::SOP_STORE: count_in = count_ff - psm_pkg::CNT_W'(2);
         default: count_in = count_ff;
      endcase
   end

   always_comb begin
      r_val_in    = r_val_ff;
      r_name_in   = r_name_ff;
      r_status_in = cmd.st_load ? err : r_status_ff;
      case (cmd.sop)
         psm_pkg::SOP_PUSH: begin
            r_val_in  = push_data[psm_pkg::VAL_W-1:0];
            r_name_in = push_data[psm_pkg::VAL_W];
         end
         psm_pkg::SOP_FETCH: begin
            r_val_in  = fetch_val;
            r_name_in = 1'b0;
         end
         psm_pkg::SOP_BIN: begin
            r_val_in  = bin_res;
            r_name_in = 1'b0;
         end
         default: begin
            if (cmd.rpt_load) begin
               if (count_ff == '0) begin
                  r_val_in  = '0;
                  r_name_in = 1'b0;
               end else if (cmd.rpt_sel == psm_pkg::RPT_TOP) begin
                  r_val_in  = b_ff;
                  r_name_in = b_tag_ff;
               end else begin
                  r_val_in  = rd_ff[psm_pkg::VAL_W-1:0];
                  r_name_in = rd_ff[psm_pkg::VAL_W];
               end
            end
         end
      endcase
   end

   // One 24 by 24 partial product per cycle.
   always_comb begin
      mul_x = cmd.mul_sel[1] ? mag_a[psm_pkg::VAL_W-1:psm_pkg::HALF_W]
                             : mag_a[psm_pkg::HALF_W-1:0];
      mul_y = cmd.mul_sel[0] ? mag_b[psm_pkg::VAL_W-1:psm_pkg::HALF_W]
                             : mag_b[psm_pkg::HALF_W-1:0];
      prod = mul_x * mul_y;
      pp = psm_pkg::PROD_W'(prod)
           << (psm_pkg::HALF_W * (32'(cmd.mul_sel[1]) + 32'(cmd.mul_sel[0])));
      acc_in = acc_ff;
      if (cmd.arith_init) acc_in = '0;
      else if (cmd.mul_step) acc_in = acc_ff + pp;
   end

   // Restoring division, one quotient bit per cycle.
   assign shifted = {rem_ff, quo_ff[psm_pkg::DIVD_W-1]};
   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      if (cmd.arith_init) begin
         quo_in = {mag_a, psm_pkg::FRAC_W'(0)};
         rem_in = '0;
      end else if (cmd.div_step) begin
         if (shifted >= {1'b0, mag_b}) begin
            rem_in = psm_pkg::VAL_W'(shifted - {1'b0, mag_b});
            quo_in = {quo_ff[psm_pkg::DIVD_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[psm_pkg::VAL_W-1:0];
            quo_in = {quo_ff[psm_pkg::DIVD_W-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      mode_in  = cmd.load_req ? req_data.mode : mode_ff;
      lit_in   = cmd.load_req ? req_data.literal : lit_ff;
      b_in     = cmd.latch_b ? rd_ff[psm_pkg::VAL_W-1:0] : b_ff;
      b_tag_in = cmd.latch_b ? rd_ff[psm_pkg::VAL_W] : b_tag_ff;
      a_in     = cmd.latch_a ? rd_ff[psm_pkg::VAL_W-1:0] : a_ff;
      a_tag_in = cmd.latch_a ? rd_ff[psm_pkg::VAL_W] : a_tag_ff;
      var_valid_in = var_valid_ff;
      if (cmd.sop == psm_pkg::SOP_STORE && var_in_range) var_valid_in[var_wr_idx] = 1'b1;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.emit) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.status        = r_status_ff;
         rsp_data_in.entry_value   = r_val_ff;
         rsp_data_in.entry_is_name = r_name_ff;
         rsp_data_in.depth         = 5'(count_ff);
         rsp_data_in.last          = cmd.last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (stk_we) stk_mem[wr_addr] <= wr_data;
      rd_ff <= stk_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.sop == psm_pkg::SOP_STORE && var_in_range) var_mem[var_wr_idx] <= b_ff;
      var_rd_ff  <= var_mem[var_rd_idx];
      var_hit_ff <= (b_ff < psm_pkg::VAL_W'(psm_pkg::NAME_COUNT)) && var_valid_ff[var_rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         var_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         var_valid_ff <= var_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff     <= mode_in;
      lit_ff      <= lit_in;
      b_ff        <= b_in;
      b_tag_ff    <= b_tag_in;
      a_ff        <= a_in;
      a_tag_ff    <= a_tag_in;
      acc_ff      <= acc_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      r_val_ff    <= r_val_in;
      r_name_ff   <= r_name_in;
      r_status_ff <= r_status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign status.mode     = mode_ff;
   assign status.err      = err;
   assign status.count    = count_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= psm_pkg::CNT_W'(psm_pkg::STACK_DEPTH))
      else $error("stack count above depth");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result word overwritten while stalled");

   a_store_pop: assert property (@(posedge clock) disable iff (reset)
      cmd.sop == psm_pkg::SOP_STORE |=> count_ff == $past(count_ff) - psm_pkg::CNT_W'(2))
      else $error("store did not pop two entries");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      cmd.sop == psm_pkg::SOP_PUSH |-> count_ff < psm_pkg::CNT_W'(psm_pkg::STACK_DEPTH))
      else $error("push onto a full stack");

endmodule
`default_nettype wire

@@ src/psm_ctrl.sv @@
// Controller: sequences each instruction through reads, checks, arithmetic and result words.
`default_nettype none
module psm_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire psm_pkg::stat_type  status,
   output psm_pkg::cmd_type        cmd
);

   psm_pkg::state_type        state_ff, state_in;
   logic [psm_pkg::CTR_W-1:0] cnt_ff, cnt_in;
   logic                      dump_last;

   assign dump_last = (cnt_ff + psm_pkg::CTR_W'(1)) == psm_pkg::CTR_W'(status.count);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         psm_pkg::S_IDLE:       if (req_valid) state_in = psm_pkg::S_RD_TOP;
         psm_pkg::S_RD_TOP:     state_in = psm_pkg::S_RD_NEXT;
         psm_pkg::S_RD_NEXT:    state_in = psm_pkg::S_LATCH_A;
         psm_pkg::S_LATCH_A:    state_in = psm_pkg::S_EVAL;
         psm_pkg::S_EVAL: begin
            state_in = psm_pkg::S_EMIT;
            if (status.err == psm_pkg::ST_OK) begin
               case (status.mode)
                  psm_pkg::MODE_FETCH: state_in = psm_pkg::S_FETCH;
                  psm_pkg::MODE_STORE: state_in = psm_pkg::S_RELOAD;
                  psm_pkg::MODE_MUL:   state_in = psm_pkg::S_MUL;
                  psm_pkg::MODE_DIV:   state_in = psm_pkg::S_DIV;
                  psm_pkg::MODE_DUMP:
                     if (status.count != '0) state_in = psm_pkg::S_DUMP_RD;
                  default:             state_in = psm_pkg::S_EMIT;
               endcase
            end
         end
         psm_pkg::S_FETCH:      state_in = psm_pkg::S_EMIT;
         psm_pkg::S_RELOAD:     state_in = psm_pkg::S_RELOAD_LAT;
         psm_pkg::S_RELOAD_LAT: state_in = psm_pkg::S_EMIT;
         psm_pkg::S_MUL:
            if (cnt_ff == psm_pkg::CTR_W'(psm_pkg::MUL_STEPS - 1)) state_in = psm_pkg::S_BIN_WB;
         psm_pkg::S_DIV:
            if (cnt_ff == psm_pkg::CTR_W'(psm_pkg::DIV_STEPS - 1)) state_in = psm_pkg::S_BIN_WB;
         psm_pkg::S_BIN_WB:     state_in = psm_pkg::S_EMIT;
         psm_pkg::S_EMIT:       if (status.out_free) state_in = psm_pkg::S_IDLE;
         psm_pkg::S_DUMP_RD:    state_in = psm_pkg::S_DUMP_LAT;
         psm_pkg::S_DUMP_LAT:   state_in = psm_pkg::S_DUMP_EMIT;
         psm_pkg::S_DUMP_EMIT:
            if (status.out_free) state_in = dump_last ? psm_pkg::S_IDLE : psm_pkg::S_DUMP_RD;
         default:               state_in = psm_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.rd_sel   = psm_pkg::RD_TOP;
      cmd.sop      = psm_pkg::SOP_NONE;
      cmd.rpt_sel  = psm_pkg::RPT_TOP;
      cmd.dump_idx = psm_pkg::SP_W'(cnt_ff);
      cmd.mul_sel  = cnt_ff[1:0];
      req_stall    = 1'b1;
      cnt_in       = cnt_ff;
      case (state_ff)
         psm_pkg::S_IDLE: begin
            req_stall    = 1'b0;
            cmd.load_req = req_valid;
         end
         psm_pkg::S_RD_NEXT: begin
            cmd.latch_b = 1'b1;
            cmd.rd_sel  = psm_pkg::RD_SECOND;
         end
         psm_pkg::S_LATCH_A: cmd.latch_a = 1'b1;
         psm_pkg::S_EVAL: begin
            cmd.st_load    = 1'b1;
            cmd.arith_init = 1'b1;
            cnt_in         = '0;
            if (status.err != psm_pkg::ST_OK) begin
               cmd.rpt_load = 1'b1;
            end else begin
               case (status.mode)
                  psm_pkg::MODE_DIGIT, psm_pkg::MODE_NAME: cmd.sop = psm_pkg::SOP_PUSH;
                  psm_pkg::MODE_STORE:                     cmd.sop = psm_pkg::SOP_STORE;
                  psm_pkg::MODE_ADD, psm_pkg::MODE_SUB:    cmd.sop = psm_pkg::SOP_BIN;
                  psm_pkg::MODE_FETCH, psm_pkg::MODE_MUL, psm_pkg::MODE_DIV: ;
                  default: cmd.rpt_load = 1'b1;
               endcase
            end
         end
         psm_pkg::S_FETCH:  cmd.sop = psm_pkg::SOP_FETCH;
         psm_pkg::S_RELOAD_LAT: begin
            cmd.rpt_load = 1'b1;
            cmd.rpt_sel  = psm_pkg::RPT_RDATA;
         end
         psm_pkg::S_MUL: begin
            cmd.mul_step = 1'b1;
            cnt_in       = cnt_ff + psm_pkg::CTR_W'(1);
         end
         psm_pkg::S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + psm_pkg::CTR_W'(1);
         end
         psm_pkg::S_BIN_WB: cmd.sop = psm_pkg::SOP_BIN;
         psm_pkg::S_EMIT: begin
            cmd.emit = status.out_free;
            cmd.last = 1'b1;
         end
         psm_pkg::S_DUMP_RD: cmd.rd_sel = psm_pkg::RD_DUMP;
         psm_pkg::S_DUMP_LAT: begin
            cmd.rpt_load = 1'b1;
            cmd.rpt_sel  = psm_pkg::RPT_RDATA;
         end
         psm_pkg::S_DUMP_EMIT: begin
            cmd.emit = status.out_free;
            cmd.last = dump_last;
            if (status.out_free) cnt_in = cnt_ff + psm_pkg::CTR_W'(1);
         end
         default: cmd.rd_sel = psm_pkg::RD_TOP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= psm_pkg::S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   a_one_last: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.last) |=> state_ff == psm_pkg::S_IDLE)
      else $error("final word did not end the instruction");

   a_div_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == psm_pkg::S_DIV |-> cnt_ff < psm_pkg::CTR_W'(psm_pkg::DIV_STEPS))
      else $error("divider ran past its step count");

endmodule
`default_nettype wire

@@ src/postfix_stack_machine.sv @@
// Top level of the postfix stack machine: controller plus datapath.
`default_nettype none
// One instruction is taken at a time, and the input stalls until its last result
// word has been written into the output register. Multiply forms four 24x24 partial
// products through one multiplier, and divide uses a restoring divider that
// produces one of 64 quotient bits per cycle. A dump reads each stack entry through
// the single read port of the stack memory and writes one word per entry; it reads
// the next entry only after the previous word has been written. The next instruction
// is accepted once the controller is back in its idle state after the last word is
// written. A stalled output register holds the instruction back until it frees.
// Variables read as zero after reset without a clearing pass; no start-up delay is
// needed.
module postfix_stack_machine (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire psm_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output psm_pkg::rsp_type       rsp_data
);

   psm_pkg::cmd_type  cmd;
   psm_pkg::stat_type status;

   psm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   psm_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

@@ verif/postfix_stack_machine_tb.sv @@
// Self-checking testbench of the postfix stack machine with a queue-fed driver and a monitor.
`default_nettype none
module postfix_stack_machine_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint LIMIT = 400000;
   localparam logic signed [47:0] SMAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] SMIN = -48'sh7FFF_FFFF_FFFF - 48'sd1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   psm_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   psm_pkg::rsp_type rsp_data;

   postfix_stack_machine uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predicted machine state.
   logic signed [47:0] stk_val [psm_pkg::STACK_DEPTH];
   logic               stk_name [psm_pkg::STACK_DEPTH];
   int                 stk_cnt;
   logic signed [47:0] vars [psm_pkg::NAME_COUNT];

   psm_pkg::req_type pending_words[$];
   psm_pkg::rsp_type expected_words[$];
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;
   logic    hold_active = 1'b0;
   int      mismatches = 0;
   longint  cycles = 0;

   function automatic void add_pending(psm_pkg::req_type w);
      pending_words = {pending_words, w};
   endfunction

   function automatic void add_expected(psm_pkg::rsp_type r);
      expected_words = {expected_words, r};
   endfunction

   function automatic logic signed [47:0] clamp_mag(logic [63:0] mag, logic neg);
      if (neg) begin
         if (mag >= 64'h8000_0000_0000) return SMIN;
         return -$signed(mag[47:0]);
      end
      if (mag > 64'h7FFF_FFFF_FFFF) return SMAX;
      return $signed(mag[47:0]);
   endfunction

   function automatic logic signed [47:0] clamp_wide(logic signed [49:0] s);
      if (s > 50'sh7FFF_FFFF_FFFF) return SMAX;
      if (s < -50'sh8000_0000_0000) return SMIN;
      return s[47:0];
   endfunction

   function automatic logic [63:0] magnitude(logic signed [47:0] v);
      logic signed [63:0] w;
      w = v;
      return (w < 0) ? 64'(-w) : 64'(w);
   endfunction

   function automatic logic signed [47:0] fixed_mul(logic signed [47:0] a,
                                                    logic signed [47:0] b);
      logic [127:0] p;
      p = magnitude(a) * magnitude(b);
      p = p >> 16;
      if (p[127:64] != 0) return (a[47] ^ b[47]) ? SMIN : SMAX;
      return clamp_mag(p[63:0], a[47] ^ b[47]);
   endfunction

   function automatic logic signed [47:0] fixed_div(logic signed [47:0] a,
                                                    logic signed [47:0] b);
      logic [63:0] q;
      q = (magnitude(a) << 16) / magnitude(b);
      return clamp_mag(q, a[47] ^ b[47]);
   endfunction

   function automatic psm_pkg::rsp_type make_word(logic [2:0] st, logic signed [47:0] v,
                                                  logic nm, int d, logic lst);
      psm_pkg::rsp_type r;
      r.status = st;
      r.entry_value = v;
      r.entry_is_name = nm;
      r.depth = 5'(d);
      r.last = lst;
      return r;
   endfunction

   task automatic predict_step(psm_pkg::req_type w);
      logic [2:0]         st;
      logic signed [47:0] a, b, r;
      int                 idx;
      st = psm_pkg::ST_OK;
      case (w.mode)
         psm_pkg::MODE_DIGIT, psm_pkg::MODE_NAME: begin
            if (stk_cnt >= psm_pkg::STACK_DEPTH) st = psm_pkg::ST_OVER;
            else begin
               stk_val[stk_cnt] = (w.mode == psm_pkg::MODE_DIGIT) ?
                  48'(w.literal) << 16 : 48'(w.literal);
               stk_name[stk_cnt] = (w.mode == psm_pkg::MODE_NAME);
               stk_cnt++;
            end
         end
         psm_pkg::MODE_FETCH: begin
            if (stk_cnt < 1) st = psm_pkg::ST_UNDER;
            else if (!stk_name[stk_cnt-1]) st = psm_pkg::ST_TYPE;
            else begin
               idx = int'(stk_val[stk_cnt-1]);
               stk_val[stk_cnt-1] = (idx < psm_pkg::NAME_COUNT) ? vars[idx] : '0;
               stk_name[stk_cnt-1] = 1'b0;
            end
         end
         psm_pkg::MODE_STORE: begin
            if (stk_cnt < 2) st = psm_pkg::ST_UNDER;
            else if (stk_name[stk_cnt-1] || !stk_name[stk_cnt-2]) st = psm_pkg::ST_TYPE;
            else begin
               idx = int'(stk_val[stk_cnt-2]);
               if (idx < psm_pkg::NAME_COUNT) vars[idx] = stk_val[stk_cnt-1];
               stk_cnt -= 2;
            end
         end
         psm_pkg::MODE_ADD, psm_pkg::MODE_SUB, psm_pkg::MODE_MUL, psm_pkg::MODE_DIV: begin
            if (stk_cnt < 2) st = psm_pkg::ST_UNDER;
            else if (stk_name[stk_cnt-1] || stk_name[stk_cnt-2]) st = psm_pkg::ST_TYPE;
            else begin
               b = stk_val[stk_cnt-1];
               a = stk_val[stk_cnt-2];
               r = '0;
               case (w.mode)
                  psm_pkg::MODE_ADD: r = clamp_wide(50'(a) + 50'(b));
                  psm_pkg::MODE_SUB: r = clamp_wide(50'(a) - 50'(b));
                  psm_pkg::MODE_MUL: r = fixed_mul(a, b);
                  default: begin
                     if (b == 0) st = psm_pkg::ST_DIV0;
                     else r = fixed_div(a, b);
                  end
               endcase
               if (st == psm_pkg::ST_OK) begin
                  stk_cnt--;
                  stk_val[stk_cnt-1] = r;
                  stk_name[stk_cnt-1] = 1'b0;
               end
            end
         end
         psm_pkg::MODE_DUMP: begin
            if (stk_cnt == 0) add_expected(make_word(psm_pkg::ST_OK, '0, 1'b0, 0, 1'b1));
            for (int i = 0; i < stk_cnt; i++)
               add_expected(make_word(psm_pkg::ST_OK, stk_val[i], stk_name[i],
                                      stk_cnt, i + 1 == stk_cnt));
            return;
         end
         default: ;
      endcase
      if (stk_cnt == 0) add_expected(make_word(st, '0, 1'b0, 0, 1'b1));
      else add_expected(make_word(st, stk_val[stk_cnt-1],
                                  stk_name[stk_cnt-1], stk_cnt, 1'b1));
   endtask

   function automatic psm_pkg::req_type mk(logic [3:0] m, logic [5:0] l);
      psm_pkg::req_type w;
      w.mode = m;
      w.literal = l;
      return w;
   endfunction

   // Driver: predicts each word at the edge where it is accepted.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_step(req_data);
            void'(pending_words.pop_front());
         end
         if (req_valid && req_stall) begin
            // Hold the stalled word.
         end else if (pending_words.size() > 0 &&
                      $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_data <= pending_words[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result word %p", rsp_data);
            end else begin
               if (rsp_data !== expected_words[0]) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %p, got %p", expected_words[0], rsp_data);
               end
               void'(expected_words.pop_front());
            end
         end
         rsp_stall <= hold_active || ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (cycles > LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic drain();
      while (pending_words.size() != 0 || req_valid || expected_words.size() != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   function automatic psm_pkg::req_type rand_word();
      psm_pkg::req_type w;
      int m;
      m = $urandom_range(99);
      if (m < 30) w = mk(psm_pkg::MODE_DIGIT, 6'($urandom_range(63)));
      else if (m < 42) w = mk(psm_pkg::MODE_NAME, 6'($urandom_range(63)));
      else if (m < 92) w = mk(4'($urandom_range(2, 8)), 6'($urandom_range(63)));
      else w = mk(4'($urandom_range(15)), 6'($urandom_range(63)));
      return w;
   endfunction

   task automatic push_random_block(int n);
      int k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(9);
         if (k < 3) begin
            // Mixed operands: name, value, then add, subtract, multiply or divide on them.
            add_pending(mk(psm_pkg::MODE_NAME, 6'($urandom_range(63))));
            add_pending(mk(psm_pkg::MODE_DIGIT, 6'($urandom_range(63))));
            add_pending(mk(4'($urandom_range(4, 7)), 6'($urandom_range(63))));
         end else begin
            add_pending(rand_word());
         end
      end
   endtask

   initial begin
      for (int i = 0; i < psm_pkg::STACK_DEPTH; i++) begin
         stk_val[i] = '0;
         stk_name[i] = 1'b0;
      end
      for (int i = 0; i < psm_pkg::NAME_COUNT; i++) vars[i] = '0;
      stk_cnt = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part: empty-stack errors, stores, arithmetic, overflow, saturation.
      add_pending(mk(psm_pkg::MODE_DUMP, 6'd0));
      add_pending(mk(psm_pkg::MODE_ADD, 6'd0));
      add_pending(mk(psm_pkg::MODE_FETCH, 6'd0));
      add_pending(mk(psm_pkg::MODE_NAME, 6'd51));
      add_pending(mk(psm_pkg::MODE_FETCH, 6'd0));
      add_pending(mk(psm_pkg::MODE_NAME, 6'd63));
      add_pending(mk(psm_pkg::MODE_DIGIT, 6'd63));
      add_pending(mk(psm_pkg::MODE_STORE, 6'd0));
      add_pending(mk(psm_pkg::MODE_NAME, 6'd0));
      add_pending(mk(psm_pkg::MODE_DIGIT, 6'd9));
      add_pending(mk(psm_pkg::MODE_STORE, 6'd0));
      add_pending(mk(psm_pkg::MODE_NAME, 6'd0));
      add_pending(mk(psm_pkg::MODE_ADD, 6'd0));
      add_pending(mk(psm_pkg::MODE_FETCH, 6'd0));
      add_pending(mk(psm_pkg::MODE_DIGIT, 6'd0));
      add_pending(mk(psm_pkg::MODE_DIV, 6'd0));
      add_pending(mk(psm_pkg::MODE_DIGIT, 6'd7));
      add_pending(mk(psm_pkg::MODE_DIV, 6'd0));
      add_pending(mk(psm_pkg::MODE_DIGIT, 6'd0));
      add_pending(mk(psm_pkg::MODE_SUB, 6'd0));
      add_pending(mk(4'd15, 6'd42));
      for (int i = 0; i < 16; i++) add_pending(mk(psm_pkg::MODE_DIGIT, 6'd63));
      add_pending(mk(psm_pkg::MODE_DUMP, 6'd0));
      for (int i = 0; i < 8; i++) add_pending(mk(psm_pkg::MODE_MUL, 6'd0));
      add_pending(mk(psm_pkg::MODE_DIGIT, 6'd0));
      add_pending(mk(psm_pkg::MODE_SUB, 6'd0));
      add_pending(mk(psm_pkg::MODE_MUL, 6'd0));
      add_pending(mk(psm_pkg::MODE_DUMP, 6'd0));
      drain();

      // Random phases with different idling.
      push_random_block(10);
      drain();
      send_idle_pct = 49;
      push_random_block(8);
      drain();
      send_idle_pct = 0;
      recv_stall_pct = 49;
      push_random_block(8);
      drain();
      send_idle_pct = 37;
      recv_stall_pct = 37;
      push_random_block(8);
      drain();
      // Long receiver hold-off while the sender keeps offering words.
      send_idle_pct = 0;
      recv_stall_pct = 0;
      fork
         begin
            hold_active <= 1'b1;
            repeat (400) @(posedge clock);
            hold_active <= 1'b0;
         end
      join_none
      for (int i = 0; i < 12; i++)
         add_pending(mk(psm_pkg::MODE_DIGIT, 6'($urandom_range(63))));
      add_pending(mk(psm_pkg::MODE_DUMP, 6'd0));
      push_random_block(2);
      drain();

      if (mismatches == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule
`default_nettype wire
